@@ hw/rtl/particle_sensor_frame_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// particle sensor frame parser assertion macros
// shared assertion forms for the parser checker
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH

// clocked assertion, quiet while reset is applied
`define PSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PSFP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/psfp_pkg.sv @@
// ----------------------------------------------------------------------------
// psfp_pkg
// shared types and constants of the particle sensor frame parser
// ----------------------------------------------------------------------------
package psfp_pkg;

    // frame layout
    localparam int FRAME_BYTES_DEF = 32;
    localparam logic [7:0] START_FIRST  = 8'h42;
    localparam logic [7:0] START_SECOND = 8'h4D;
    localparam int BODY_FIRST_IDX = 2;
    localparam int PM_SMALL_HI  = 4;
    localparam int PM_SMALL_LO  = 5;
    localparam int PM_FINE_HI   = 6;
    localparam int PM_FINE_LO   = 7;
    localparam int PM_COARSE_HI = 8;
    localparam int PM_COARSE_LO = 9;

    // hour keeping
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;

    // register map
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_GOOD_LIMIT      = 2'd0;
    localparam logic [1:0] REG_MODERATE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_FRAMES_PER_HOUR = 2'd2;
    localparam logic [15:0] GOOD_LIMIT_RST      = 16'd12;
    localparam logic [15:0] MODERATE_LIMIT_RST  = 16'd35;
    localparam logic [15:0] FRAMES_PER_HOUR_RST = 16'd60;

    // result stream
    localparam int OUT_DATA_W = 56;

    // quality classes
    localparam logic [1:0] QUAL_GOOD      = 2'd0;
    localparam logic [1:0] QUAL_MODERATE  = 2'd1;
    localparam logic [1:0] QUAL_UNHEALTHY = 2'd2;

    // sync phases
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] good_limit;
        logic [15:0] moderate_limit;
        logic [15:0] frames_per_hour;
    } cfg_t;

    // completed frame from the parser
    typedef struct packed {
        logic        done;
        logic [15:0] pm_small;
        logic [15:0] pm_fine;
        logic [15:0] pm_coarse;
        logic        sum_ok;
    } frame_t;

endpackage

@@ hw/rtl/psfp_regs.sv @@
// ----------------------------------------------------------------------------
// psfp_regs
// configuration registers behind the bus port
// ----------------------------------------------------------------------------
module psfp_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psfp_pkg::ADDR_W-1:0]    paddr,
    input  logic [psfp_pkg::PDATA_W-1:0]   pwdata,
    output logic [psfp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output psfp_pkg::cfg_t                 cfg
);
    import psfp_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_limit      <= GOOD_LIMIT_RST;
            cfg_reg.moderate_limit  <= MODERATE_LIMIT_RST;
            cfg_reg.frames_per_hour <= FRAMES_PER_HOUR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GOOD_LIMIT:      cfg_reg.good_limit      <= pwdata[15:0];
                REG_MODERATE_LIMIT:  cfg_reg.moderate_limit  <= pwdata[15:0];
                REG_FRAMES_PER_HOUR: cfg_reg.frames_per_hour <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_GOOD_LIMIT:      prdata = {16'd0, cfg_reg.good_limit};
            REG_MODERATE_LIMIT:  prdata = {16'd0, cfg_reg.moderate_limit};
            REG_FRAMES_PER_HOUR: prdata = {16'd0, cfg_reg.frames_per_hour};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/psfp_parse.sv @@
// ----------------------------------------------------------------------------
// psfp_parse
// start pair hunt, byte position tracking, running sum and word capture
// ----------------------------------------------------------------------------
module psfp_parse #(
    parameter int FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output psfp_pkg::frame_t  frame
);
    import psfp_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] SUM_END  = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       sum_reg, sum_next;
    logic [15:0]       small_reg, small_next;
    logic [15:0]       fine_reg, fine_next;
    logic [15:0]       coarse_reg, coarse_next;
    logic [15:0]       rcv_reg, rcv_next;
    logic              last_byte;

    assign last_byte = (phase_reg == PH_BODY) && (idx_reg == LAST_IDX);

    // next state of the parser
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        small_next  = small_reg;
        fine_next   = fine_reg;
        coarse_next = coarse_reg;
        rcv_next    = rcv_reg;
        unique case (phase_reg)
            PH_SECOND:
            begin
                if (rx_byte == START_SECOND)
                begin
                    phase_next = PH_BODY;
                    idx_next   = IDX_W'(BODY_FIRST_IDX);
                    sum_next   = sum_reg + {8'd0, rx_byte};
                end
                else if (rx_byte == START_FIRST)
                    sum_next = {8'd0, rx_byte};
                else
                    phase_next = PH_HUNT;
            end
            PH_BODY:
            begin
                if (idx_reg < SUM_END)
                    sum_next = sum_reg + {8'd0, rx_byte};
                else if (idx_reg == SUM_END)
                    rcv_next[15:8] = rx_byte;
                else
                    rcv_next[7:0] = rx_byte;
                if (idx_reg == IDX_W'(PM_SMALL_HI))  small_next[15:8]  = rx_byte;
                if (idx_reg == IDX_W'(PM_SMALL_LO))  small_next[7:0]   = rx_byte;
                if (idx_reg == IDX_W'(PM_FINE_HI))   fine_next[15:8]   = rx_byte;
                if (idx_reg == IDX_W'(PM_FINE_LO))   fine_next[7:0]    = rx_byte;
                if (idx_reg == IDX_W'(PM_COARSE_HI)) coarse_next[15:8] = rx_byte;
                if (idx_reg == IDX_W'(PM_COARSE_LO)) coarse_next[7:0]  = rx_byte;
                if (last_byte)
                begin
                    phase_next = PH_HUNT;
                    idx_next   = '0;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                // hunting, and the unused code behaves the same
                phase_next = PH_HUNT;
                if (rx_byte == START_FIRST)
                begin
                    phase_next = PH_SECOND;
                    sum_next   = {8'd0, rx_byte};
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // captured words
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            small_reg  <= small_next;
            fine_reg   <= fine_next;
            coarse_reg <= coarse_next;
            rcv_reg    <= rcv_next;
        end
    end

    // frame summary on the last byte
    always_comb
    begin
        frame.done      = last_byte;
        frame.pm_small  = small_reg;
        frame.pm_fine   = fine_reg;
        frame.pm_coarse = coarse_reg;
        frame.sum_ok    = (sum_reg == {rcv_reg[15:8], rx_byte});
    end

endmodule

@@ hw/rtl/psfp_result.sv @@
// ----------------------------------------------------------------------------
// psfp_result
// quality class, hour counting and the result register
// ----------------------------------------------------------------------------
module psfp_result (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  psfp_pkg::frame_t                    frame,
    input  psfp_pkg::cfg_t                      cfg,
    output logic                                in_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [psfp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import psfp_pkg::*;

    logic                   valid_reg;
    logic [OUT_DATA_W-1:0]  data_reg;
    logic [15:0]            fih_reg, fih_next;
    logic [4:0]             hour_reg, hour_next;
    logic [15:0]            fih_inc;
    logic [15:0]            limit;
    logic [4:0]             hour_inc;
    logic [1:0]             quality;
    logic                   emit;

    assign in_ready = !valid_reg || m_tready;
    assign emit     = fire && frame.done;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // class from the fine fraction, good tested first
    always_comb
    begin
        priority if (frame.pm_fine < cfg.good_limit)
            quality = QUAL_GOOD;
        else if (frame.pm_fine < cfg.moderate_limit)
            quality = QUAL_MODERATE;
        else
            quality = QUAL_UNHEALTHY;
    end

    // hour advance, zero frames per hour counts as one
    always_comb
    begin
        limit    = (cfg.frames_per_hour == 16'd0) ? 16'd1 : cfg.frames_per_hour;
        fih_inc  = fih_reg + 16'd1;
        hour_inc = hour_reg + 5'd1;
        if (fih_inc >= limit)
        begin
            fih_next  = '0;
            hour_next = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc;
        end
        else
        begin
            fih_next  = fih_inc;
            hour_next = hour_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fih_reg   <= '0;
            hour_reg  <= '0;
        end
        else
        begin
            if (emit)
            begin
                valid_reg <= 1'b1;
                fih_reg   <= fih_next;
                hour_reg  <= hour_next;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
            data_reg <= {hour_reg, quality, frame.sum_ok,
                         frame.pm_coarse, frame.pm_fine, frame.pm_small};
    end

endmodule

@@ hw/rtl/particle_sensor_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser_unit
// byte stream parser for particle sensor frames
// ----------------------------------------------------------------------------
// Serial bytes enter on the s_ stream, one byte per request. The block hunts
// for the start pair 0x42 0x4D, collects the rest of a FRAME_BYTES frame and
// gives one request on the m_ stream per complete frame: the three PM words,
// a checksum match flag, an air quality class and an hour of day label.
// Limits and frames per hour are set through the bus port at 0x0, 0x4, 0x8.
// One byte is taken every cycle while s_tready is high; the result of a frame
// appears on m_tvalid in the cycle after its last byte is taken. The single
// result register sits between them; the parser state updates once per byte.
// Reset clears the result valid flag, the parser back to hunting and the hour
// counters, and loads the register defaults. While a result waits in the
// result register, s_tready follows m_tready: a stalled receiver holds off
// every byte, whether or not it ends a frame, and a byte is taken in the
// same cycle as the waiting result.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser_unit #(
    parameter int FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // rx_byte[7:0]
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pm_small[15:0], pm_fine[31:16], pm_coarse[47:32], sum_ok[48],
    // quality_class[50:49], hour_of_day[55:51]
    output logic [psfp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psfp_pkg::ADDR_W-1:0]         paddr,
    input  logic [psfp_pkg::PDATA_W-1:0]        pwdata,
    output logic [psfp_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import psfp_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   fire;

    assign fire = s_tvalid && s_tready;

    // configuration registers
    psfp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // byte parser
    psfp_parse #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (s_tdata),
        .frame   (frame)
    );

    // result stage
    psfp_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .frame    (frame),
        .cfg      (cfg),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/psfp_checker.sv @@
// ----------------------------------------------------------------------------
// psfp_checker
// port level checks of the frame parser
// ----------------------------------------------------------------------------
`include "particle_sensor_frame_parser_unit_defines.svh"

module psfp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic [psfp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready
);
    import psfp_pkg::*;

    // a stalled result holds
    `PSFP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // input only stalls behind a waiting result
    `PSFP_ASSERT(a_in_stall, !s_tready |-> m_tvalid && !m_tready, "input stalled without cause")

    // hour label stays within the day
    `PSFP_ASSERT(a_hour_range, m_tvalid |-> m_tdata[55:51] < HOURS_PER_DAY, "hour label out of range")

    // quality class is one of three
    `PSFP_ASSERT(a_qual_range, m_tvalid |-> m_tdata[50:49] != 2'b11, "quality class out of range")

    // no result once reset has been seen at an edge
    `PSFP_ASSERT_RST(a_rst_quiet, !rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind particle_sensor_frame_parser_unit psfp_checker u_psfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

@@ test/tb_particle_sensor_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_sensor_frame_parser_unit
// self-checking bench for the particle sensor frame parser
// ----------------------------------------------------------------------------
// Serial bytes are fed on the s_ stream from a queue. Every accepted byte
// runs through a bit-accurate parser model that keeps its own copy of the
// sync state, sums, captured words and hour counters. Each result request
// on the m_ stream is compared field by field with the oldest predicted
// frame. Directed frames hit the class boundaries, word extremes and sync
// corner cases, then mixed traffic of whole, cut-short and corrupted frames
// and noise runs under several register settings, with random stalls on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_particle_sensor_frame_parser_unit;
    import psfp_pkg::*;

    localparam int PKT_BYTES    = FRAME_BYTES_DEF;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 300;

    // result fields, pm_small in the lowest bits
    typedef struct packed {
        logic [4:0]  hour_of_day;
        logic [1:0]  quality_class;
        logic        sum_ok;
        logic [15:0] pm_coarse;
        logic [15:0] pm_fine;
        logic [15:0] pm_small;
    } frame_report_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // pending serial bytes and predicted frame reports
    logic [7:0]    byte_queue[$];
    frame_report_t frame_results[$];

    // parser model state
    phase_t      sync_ph          = PH_HUNT;
    logic [5:0]  body_pos         = '0;
    logic [15:0] sum_acc          = '0;
    logic [15:0] small_w          = '0;
    logic [15:0] fine_w           = '0;
    logic [15:0] coarse_w         = '0;
    logic [15:0] rx_sum           = '0;
    logic [15:0] frames_this_hour = '0;
    logic [4:0]  hour_now         = '0;
    cfg_t        active_cfg       = '{GOOD_LIMIT_RST, MODERATE_LIMIT_RST, FRAMES_PER_HOUR_RST};

    // idling control
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap      = 0;
    int snk_gap      = 0;
    int hold_left    = 0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;

    // run statistics
    int         fail_count     = 0;
    int         bytes_taken    = 0;
    int         frames_checked = 0;
    int         bad_sums       = 0;
    int         hour_wraps     = 0;
    int         reg_writes     = 0;
    logic [4:0] last_hour      = '0;

    particle_sensor_frame_parser_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #(10_000_000);
        $display("[particle_sensor_frame_parser_unit] ERROR");
        $finish;
    end

    // big-endian byte placement: even position is the high byte
    function automatic logic [15:0] set_be_byte(input logic [15:0] word, input int unsigned pos,
                                                input logic [7:0] b);
        if (pos % 2 == 0)
            return {b, word[7:0]};
        return {word[15:8], b};
    endfunction

    // parser model: one accepted byte, at most one predicted report
    function automatic void parse_rx_byte(input logic [7:0] b);
        frame_report_t rep;
        logic [15:0]   hour_limit;
        int unsigned   pos;
        if (sync_ph == PH_SECOND)
        begin
            if (b == START_SECOND)
            begin
                sync_ph  = PH_BODY;
                body_pos = 6'(BODY_FIRST_IDX);
                sum_acc  = sum_acc + {8'h00, b};
            end
            else if (b == START_FIRST)
                sum_acc = {8'h00, b};
            else
                sync_ph = PH_HUNT;
        end
        else if (sync_ph != PH_BODY)
        begin
            sync_ph = PH_HUNT;
            if (b == START_FIRST)
            begin
                sync_ph  = PH_SECOND;
                sum_acc  = {8'h00, b};
                small_w  = '0;
                fine_w   = '0;
                coarse_w = '0;
                rx_sum   = '0;
            end
        end
        else
        begin
            pos = body_pos;
            // checksum covers everything but the trailing word
            if (pos < PKT_BYTES - 2)
                sum_acc = sum_acc + {8'h00, b};
            else
                rx_sum = set_be_byte(rx_sum, pos - (PKT_BYTES - 2), b);
            if (pos == PM_SMALL_HI || pos == PM_SMALL_LO)
                small_w = set_be_byte(small_w, pos, b);
            else if (pos == PM_FINE_HI || pos == PM_FINE_LO)
                fine_w = set_be_byte(fine_w, pos, b);
            else if (pos == PM_COARSE_HI || pos == PM_COARSE_LO)
                coarse_w = set_be_byte(coarse_w, pos, b);

            if (pos < PKT_BYTES - 1)
                body_pos = body_pos + 6'd1;
            else
            begin
                rep.pm_small  = small_w;
                rep.pm_fine   = fine_w;
                rep.pm_coarse = coarse_w;
                rep.sum_ok    = (sum_acc == rx_sum);
                if (fine_w < active_cfg.good_limit)
                    rep.quality_class = QUAL_GOOD;
                else if (fine_w < active_cfg.moderate_limit)
                    rep.quality_class = QUAL_MODERATE;
                else
                    rep.quality_class = QUAL_UNHEALTHY;
                rep.hour_of_day = hour_now;
                frame_results.push_back(rep);

                // hour keeping, zero frames per hour acts as one
                hour_limit       = (active_cfg.frames_per_hour == 0) ? 16'd1
                                                                      : active_cfg.frames_per_hour;
                frames_this_hour = frames_this_hour + 16'd1;
                if (frames_this_hour >= hour_limit)
                begin
                    frames_this_hour = '0;
                    hour_now         = hour_now + 5'd1;
                    if (hour_now >= HOURS_PER_DAY)
                        hour_now = '0;
                end
                sync_ph  = PH_HUNT;
                body_pos = '0;
            end
        end
    endfunction

    // build a frame and queue its first keep bytes
    function automatic void queue_frame(input logic [15:0] pm_s, input logic [15:0] pm_f,
                                        input logic [15:0] pm_c, input bit bad_sum,
                                        input bit sync_inside, input int keep);
        logic [7:0]  fb [PKT_BYTES];
        logic [15:0] csum;
        int          at;
        fb[0] = START_FIRST;
        fb[1] = START_SECOND;
        if ($urandom_range(1) == 0)
            {fb[2], fb[3]} = 16'(PKT_BYTES - 4);
        else
            {fb[2], fb[3]} = 16'($urandom);
        {fb[4], fb[5]} = pm_s;
        {fb[6], fb[7]} = pm_f;
        {fb[8], fb[9]} = pm_c;
        for (int i = 10; i < PKT_BYTES - 2; i++)
            fb[i] = 8'($urandom);
        // a start pair buried in the body must not resync
        if (sync_inside)
        begin
            at         = $urandom_range(2, PKT_BYTES - 4);
            fb[at]     = START_FIRST;
            fb[at + 1] = START_SECOND;
        end
        csum = '0;
        for (int i = 0; i < PKT_BYTES - 2; i++)
            csum = csum + {8'h00, fb[i]};
        if (bad_sum)
            csum = csum ^ (16'd1 << $urandom_range(15));
        {fb[PKT_BYTES - 2], fb[PKT_BYTES - 1]} = csum;
        for (int i = 0; i < keep; i++)
            byte_queue.push_back(fb[i]);
    endfunction

    // pm2.5 values, half of the picks clustered around the current class limits
    function automatic logic [15:0] pick_fine();
        logic [15:0] lim;
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       lim = active_cfg.good_limit;
            2:       lim = active_cfg.moderate_limit;
            default: return 16'($urandom_range(0, 63));
        endcase
        return lim + 16'($urandom_range(0, 2)) - 16'd1;
    endfunction

    // mixed traffic: mostly whole frames, some cut short, noise and false starts
    function automatic void queue_mixed_traffic(input int n_bytes);
        int start_len;
        int pick;
        start_len = byte_queue.size();
        while (byte_queue.size() - start_len < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
                queue_frame(16'($urandom), pick_fine(), 16'($urandom),
                            $urandom_range(99) < 15, $urandom_range(99) < 20, PKT_BYTES);
            else if (pick < 78)
                queue_frame(16'($urandom), pick_fine(), 16'($urandom), 1'b0, 1'b0,
                            $urandom_range(2, PKT_BYTES - 1));
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    case ($urandom_range(3))
                        0:       byte_queue.push_back(START_FIRST);
                        1:       byte_queue.push_back(START_SECOND);
                        default: byte_queue.push_back(8'($urandom));
                    endcase
                end
            end
            else
            begin
                byte_queue.push_back(START_FIRST);
                repeat ($urandom_range(0, 3))
                    byte_queue.push_back(START_FIRST);
                byte_queue.push_back(8'($urandom));
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // register read with readback compare
    task automatic read_reg(input logic [1:0] idx, input logic [15:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[15:0] !== want)
        begin
            $error("register %0d readback mismatch: expected %0d, got %0d", idx, want, prdata[15:0]);
            fail_count++;
        end
    endtask

    // register write, model copy updated at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GOOD_LIMIT:      active_cfg.good_limit      = value;
            REG_MODERATE_LIMIT:  active_cfg.moderate_limit  = value;
            REG_FRAMES_PER_HOUR: active_cfg.frames_per_hour = value;
            default: ;
        endcase
        reg_writes++;
        read_reg(idx, value);
    endtask

    // hold until every byte is in and every report has come out
    task automatic wait_drained();
        do @(posedge clk);
        while (byte_queue.size() != 0 || s_tvalid || frame_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte sender with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap != 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
            begin
                src_gap = $urandom_range(17);
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                s_tdata  <= byte_queue.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // accepted byte requests feed the model
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            parse_rx_byte(s_tdata);
            bytes_taken++;
        end
    end

    // receiver ready with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (snk_gap != 0)
        begin
            snk_gap--;
            m_tready <= 1'b0;
        end
        else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct)
        begin
            snk_gap = $urandom_range(17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result requests against the oldest prediction
    always @(posedge clk)
    begin : result_check
        frame_report_t got;
        frame_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = frame_report_t'(m_tdata);
            if (frame_results.size() == 0)
            begin
                $error("result request with no frame pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = frame_results.pop_front();
                check_field("pm_small", want.pm_small, got.pm_small);
                check_field("pm_fine", want.pm_fine, got.pm_fine);
                check_field("pm_coarse", want.pm_coarse, got.pm_coarse);
                check_field("sum_ok", 16'(want.sum_ok), 16'(got.sum_ok));
                check_field("quality_class", 16'(want.quality_class), 16'(got.quality_class));
                check_field("hour_of_day", 16'(want.hour_of_day), 16'(got.hour_of_day));
                frames_checked++;
                if (!want.sum_ok)
                    bad_sums++;
                if (want.hour_of_day < last_hour)
                    hour_wraps++;
                last_hour = want.hour_of_day;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        logic [15:0] good_v;
        logic [15:0] mod_v;
        logic [15:0] fph_v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults after reset
        read_reg(REG_GOOD_LIMIT, GOOD_LIMIT_RST);
        read_reg(REG_MODERATE_LIMIT, MODERATE_LIMIT_RST);
        read_reg(REG_FRAMES_PER_HOUR, FRAMES_PER_HOUR_RST);

        // directed frames: word extremes, class boundaries, sync corner cases
        src_idle_pct = 15;
        snk_idle_pct = 15;
        queue_frame(16'h0000, GOOD_LIMIT_RST - 16'd1, 16'hFFFF, 1'b0, 1'b0, PKT_BYTES);
        queue_frame(16'hFFFF, GOOD_LIMIT_RST, 16'h0000, 1'b0, 1'b0, PKT_BYTES);
        queue_frame(16'd1, MODERATE_LIMIT_RST - 16'd1, 16'd2, 1'b0, 1'b0, PKT_BYTES);
        queue_frame(16'd3, MODERATE_LIMIT_RST, 16'd4, 1'b1, 1'b0, PKT_BYTES);
        byte_queue.push_back(START_FIRST);
        queue_frame(16'h1234, 16'hFFFF, 16'hABCD, 1'b0, 1'b0, PKT_BYTES);
        byte_queue.push_back(START_FIRST);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(START_SECOND);
        byte_queue.push_back(8'hFF);
        queue_frame(16'h00FF, 16'hFF00, 16'h8001, 1'b0, 1'b1, PKT_BYTES);
        wait_drained();

        // frames per hour lowered once the hour is already past the new value
        write_reg(REG_FRAMES_PER_HOUR, 16'd3);
        repeat (2)
            queue_frame(16'($urandom), pick_fine(), 16'($urandom), 1'b0, 1'b0, PKT_BYTES);
        wait_drained();

        // hour steps every frame, limits at the extremes, long hold-off
        write_reg(REG_GOOD_LIMIT, 16'h0000);
        write_reg(REG_MODERATE_LIMIT, 16'hFFFF);
        write_reg(REG_FRAMES_PER_HOUR, 16'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 1'b1;
        repeat (4)
            queue_frame(16'($urandom), pick_fine(), 16'($urandom),
                        $urandom_range(99) < 20, 1'b0, PKT_BYTES);
        queue_frame(16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, PKT_BYTES);
        wait_drained();

        // zero frames per hour, limits out of order; ends part-way into a frame
        write_reg(REG_GOOD_LIMIT, 16'hFFFF);
        write_reg(REG_MODERATE_LIMIT, 16'h0000);
        write_reg(REG_FRAMES_PER_HOUR, 16'd0);
        src_idle_pct = 20;
        snk_idle_pct = 20;
        queue_frame(16'd0, 16'hFFFE, 16'd0, 1'b0, 1'b0, PKT_BYTES);
        queue_frame(16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, PKT_BYTES);
        queue_mixed_traffic(60);
        queue_frame(16'h4242, 16'h4D4D, 16'h424D, 1'b0, 1'b0, 15);
        wait_drained();

        // registers changed while a frame is half collected
        write_reg(REG_GOOD_LIMIT, 16'd100);
        write_reg(REG_MODERATE_LIMIT, 16'd200);
        write_reg(REG_FRAMES_PER_HOUR, 16'hFFFF);
        queue_mixed_traffic(60);
        wait_drained();

        // random settings with mixed traffic
        for (int ph = 0; ph < 3; ph++)
        begin
            case ($urandom_range(3))
                0:       good_v = 16'h0000;
                1:       good_v = 16'hFFFF;
                2:       good_v = 16'($urandom);
                default: good_v = 16'($urandom_range(0, 200));
            endcase
            case ($urandom_range(3))
                0:       mod_v = 16'h0000;
                1:       mod_v = 16'hFFFF;
                2:       mod_v = 16'($urandom);
                default: mod_v = 16'($urandom_range(0, 400));
            endcase
            case ($urandom_range(5))
                0:       fph_v = 16'd0;
                1:       fph_v = 16'hFFFF;
                default: fph_v = 16'($urandom_range(1, 4));
            endcase
            write_reg(REG_GOOD_LIMIT, good_v);
            write_reg(REG_MODERATE_LIMIT, mod_v);
            write_reg(REG_FRAMES_PER_HOUR, fph_v);
            src_idle_pct = (ph == 1) ? 0 : $urandom_range(5, 30);
            snk_idle_pct = (ph == 1) ? 0 : $urandom_range(5, 30);
            queue_mixed_traffic(50);
            wait_drained();
        end

        // closing stretch without idling
        write_reg(REG_GOOD_LIMIT, GOOD_LIMIT_RST);
        write_reg(REG_MODERATE_LIMIT, MODERATE_LIMIT_RST);
        write_reg(REG_FRAMES_PER_HOUR, 16'd2);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_mixed_traffic(40);
        queue_frame(16'($urandom), pick_fine(), 16'($urandom), 1'b0, 1'b0, PKT_BYTES);
        wait_drained();

        $display("covered %0d bytes and %0d frames (%0d with a bad checksum), %0d day wraps",
                 bytes_taken, frames_checked, bad_sums, hour_wraps);
        $display("across %0d register writes with both sides stalling", reg_writes);
        if (fail_count == 0)
            $display("[particle_sensor_frame_parser_unit] OK");
        else
            $display("[particle_sensor_frame_parser_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/psfp_pkg.sv
hw/rtl/psfp_regs.sv
hw/rtl/psfp_parse.sv
hw/rtl/psfp_result.sv
hw/rtl/particle_sensor_frame_parser_unit.sv
hw/rtl/psfp_checker.sv
test/tb_particle_sensor_frame_parser_unit.sv
